[rtl/quicksort_first_pivot_sorter_defines.svh]
// assertion macros used by the sorter top level
`ifndef QUICKSORT_FIRST_PIVOT_SORTER_DEFINES_SVH
`define QUICKSORT_FIRST_PIVOT_SORTER_DEFINES_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define QFPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never be seen at a clock edge outside reset
`define QFPS_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define QFPS_ASSERT(lbl, prop, msg)
`define QFPS_NEVER(lbl, cond, msg)
`endif

`endif

[rtl/qfps_pkg.sv]
// shared constants and types of the sorter
package qfps_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int VALUE_WIDTH  = 32;
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic [CNT_W-1:0]              count_t;

    // what every cell does in a cycle
    typedef enum logic [1:0] {
        OP_HOLD  = 2'd0,
        OP_LOAD  = 2'd1,
        OP_SHIFT = 2'd2
    } cell_op_t;

    // broadcast from the controller to all cells
    typedef struct packed {
        cell_op_t op;
        value_t   ins;
    } cell_ctrl_t;

    // what a cell shows its neighbours
    typedef struct packed {
        logic   valid;
        logic   keep;
        value_t value;
    } cell_link_t;

    localparam cell_link_t LINK_HEAD = '{valid: 1'b0, keep: 1'b1, value: '0};
    localparam cell_link_t LINK_TAIL = '{valid: 1'b0, keep: 1'b0, value: '0};

endpackage

[rtl/qfps_cell.sv]
// one cell of the sorting chain: holds one value, inserts or shifts left
module qfps_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  qfps_pkg::cell_ctrl_t ctrl,
    input  qfps_pkg::cell_link_t prev_link,
    input  qfps_pkg::cell_link_t next_link,
    output qfps_pkg::cell_link_t link
);
    import qfps_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    value_t value_reg;
    value_t value_next;
    logic   keep;

    // a held value not above the incoming one stays where it is
    assign keep = valid_reg && (value_reg <= ctrl.ins);

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        unique case (ctrl.op)
            OP_LOAD:
            begin
                if (!keep)
                begin
                    if (prev_link.keep)
                    begin
                        valid_next = 1'b1;
                        value_next = ctrl.ins;
                    end
                    else
                    begin
                        valid_next = prev_link.valid;
                        value_next = prev_link.value;
                    end
                end
            end
            OP_SHIFT:
            begin
                valid_next = next_link.valid;
                value_next = next_link.value;
            end
            default:
            begin
                valid_next = valid_reg;
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign link.valid = valid_reg;
    assign link.keep  = keep;
    assign link.value = value_reg;

endmodule

[rtl/quicksort_first_pivot_sorter.sv]
// sorter top level: loads items into the cell chain, then drains it in order
// loading: one item per cycle, start accepted whenever busy is low
// the item marked last, or the one that fills all MAX_ELEMENTS cells, starts the drain
// first result in the cycle after that item, then one result per cycle for n items
// all results leave through the single chain output, the front cell
// reset clears the valid flag of every cell and the control state; the receiver cannot stall
`include "quicksort_first_pivot_sorter_defines.svh"

module quicksort_first_pivot_sorter
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  qfps_pkg::value_t      value,
    input  logic                  last,
    output logic                  strobe,
    output qfps_pkg::value_t      sorted_value,
    output logic                  final_res
);
    import qfps_pkg::*;

    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    count_t     count_reg;
    count_t     count_next;
    logic       accept;
    logic       fill;
    cell_ctrl_t ctrl;
    cell_link_t links [MAX_ELEMENTS];

    assign busy   = (state_reg == ST_DRAIN);
    assign accept = start && !busy;
    assign fill   = (count_reg == CNT_W'(MAX_ELEMENTS - 1));

    // the chain front is always the smallest value held
    assign strobe       = busy && links[0].valid;
    assign sorted_value = links[0].value;
    assign final_res    = strobe && !links[1].valid;

    always_comb
    begin
        ctrl.ins = value;
        if (accept)
        begin
            ctrl.op = OP_LOAD;
        end
        else if (busy)
        begin
            ctrl.op = OP_SHIFT;
        end
        else
        begin
            ctrl.op = OP_HOLD;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (last || fill)
                    begin
                        state_next = ST_DRAIN;
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (final_res || !links[0].valid)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
                count_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    for (genvar k = 0; k < MAX_ELEMENTS; k++)
    begin : g_cell
        cell_link_t prev_l;
        cell_link_t next_l;

        if (k == 0)
        begin : g_head
            assign prev_l = LINK_HEAD;
        end
        else
        begin : g_mid_prev
            assign prev_l = links[k-1];
        end

        if (k == MAX_ELEMENTS - 1)
        begin : g_tail
            assign next_l = LINK_TAIL;
        end
        else
        begin : g_mid_next
            assign next_l = links[k+1];
        end

        qfps_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .prev_link (prev_l),
            .next_link (next_l),
            .link      (links[k])
        );
    end

    // every drain cycle hands out an item
    `QFPS_ASSERT(a_drain_emits, busy |-> strobe, "drain cycle without a result")
    `QFPS_ASSERT(a_final_ends, (strobe && final_res) |=> !busy, "busy after final result")
    `QFPS_ASSERT(a_last_drains, (accept && last) |=> busy, "no drain after last item")
    `QFPS_NEVER(a_load_quiet, strobe && !busy, "result while loading")
    `QFPS_ASSERT(a_count_idle, busy |-> (count_reg == '0), "count not cleared for drain")

endmodule
